[rtl/decimal_text_to_number_defines.svh]
// Assertion macros for the decimal text parser.
// Taken in by the top level; depends on clk and rst in the including scope.
`ifndef DECIMAL_TEXT_TO_NUMBER_DEFINES_SVH
`define DECIMAL_TEXT_TO_NUMBER_DEFINES_SVH

// Check a condition at every edge outside reset.
`define DTN_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define DTN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dtn_pkg.sv]
// Shared types, codes and tables of the decimal text parser.
// No dependencies; used by every module of the block.
package dtn_pkg;

  localparam int FRAC_BITS_DEF       = 16;
  localparam int MAX_FRAC_DIGITS_DEF = 9;
  localparam int COUNT_MAX_DEF       = 255;

  localparam int QUEUE_DEPTH = 4;
  localparam int POW10_W     = 30;
  localparam int VALUE_W     = 48;
  localparam int PADDR_W     = 3;

  localparam logic [1:0] MODE_UINT = 2'd0;
  localparam logic [1:0] MODE_SINT = 2'd1;
  localparam logic [1:0] MODE_REAL = 2'd2;

  localparam logic [2:0] CLS_DIGIT = 3'd0;
  localparam logic [2:0] CLS_PLUS  = 3'd1;
  localparam logic [2:0] CLS_MINUS = 3'd2;
  localparam logic [2:0] CLS_DOT   = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [PADDR_W-1:0] ADDR_NUMBER_MODE = 3'd0;

  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] digit;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic       neg;
    logic [1:0] mode;
    logic [7:0] consumed;
  } hand_ctl_t;

  function automatic logic [POW10_W-1:0] pow10(input logic [3:0] n);
    logic [POW10_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

[rtl/dtn_front.sv]
// Input side of the parser: takes characters and classifies them.
// Depends on dtn_pkg; feeds dtn_queue.
module dtn_front (
  input  logic                 char_valid,
  output logic                 char_stall,
  input  logic [7:0]           char_code,
  input  logic                 field_last,
  input  dtn_pkg::queue_stat_t q_stat,
  output logic                 push,
  output dtn_pkg::char_item_t  push_item
);

  assign char_stall = q_stat.full;
  assign push       = char_valid && !q_stat.full;

  always_comb begin
    push_item.digit = 4'(char_code - dtn_pkg::CH_ZERO);
    push_item.last  = field_last;
    if (char_code inside {[dtn_pkg::CH_ZERO:dtn_pkg::CH_NINE]}) begin
      push_item.cls = dtn_pkg::CLS_DIGIT;
    end else if (char_code == dtn_pkg::CH_PLUS) begin
      push_item.cls = dtn_pkg::CLS_PLUS;
    end else if (char_code == dtn_pkg::CH_MINUS) begin
      push_item.cls = dtn_pkg::CLS_MINUS;
    end else if (char_code == dtn_pkg::CH_DOT) begin
      push_item.cls = dtn_pkg::CLS_DOT;
    end else begin
      push_item.cls = dtn_pkg::CLS_OTHER;
    end
  end

endmodule

[rtl/dtn_queue.sv]
// Short queue of classified characters between front and parser.
// Depends on dtn_pkg.
module dtn_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dtn_pkg::char_item_t  push_item,
  input  logic                 pop,
  output dtn_pkg::char_item_t  pop_item,
  output dtn_pkg::queue_stat_t q_stat
);

  localparam int PTR_W = $clog2(dtn_pkg::QUEUE_DEPTH);
  localparam int LVL_W = $clog2(dtn_pkg::QUEUE_DEPTH + 1);

  dtn_pkg::char_item_t slot [dtn_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;

  assign pop_item     = slot[rd_ptr];
  assign q_stat.full  = (level == LVL_W'(dtn_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (level == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        level <= LVL_W'(level + 1'b1);
      end else if (pop && !push) begin
        level <= LVL_W'(level - 1'b1);
      end
    end
  end

endmodule

[rtl/dtn_parse.sv]
// Parser state: applies one queued character per cycle, a last one at scale_idle.
// Depends on dtn_pkg; hands finished fields to dtn_scale.
module dtn_parse #(
  parameter int MAX_FRAC_DIGITS = dtn_pkg::MAX_FRAC_DIGITS_DEF,
  parameter int COUNT_MAX       = dtn_pkg::COUNT_MAX_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [1:0]                                 mode,
  input  dtn_pkg::queue_stat_t                       q_stat,
  input  dtn_pkg::char_item_t                        item,
  output logic                                       pop,
  input  logic                                       scale_idle,
  output dtn_pkg::hand_ctl_t                         hand,
  output logic [31:0]                                hand_acc,
  output logic [$clog2(10**MAX_FRAC_DIGITS)-1:0]     hand_facc,
  output logic [$clog2(MAX_FRAC_DIGITS+1)-1:0]       hand_fcnt
);

  localparam int FACC_W = $clog2(10**MAX_FRAC_DIGITS);
  localparam int FCNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int CNT_W  = $clog2(COUNT_MAX + 1);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_WHOLE = 2'd1;
  localparam logic [1:0] PH_FRAC  = 2'd2;

  logic [1:0]        phase, phase_next;
  logic              neg, neg_next;
  logic [31:0]       acc, acc_next;
  logic              seen, seen_next;
  logic [FACC_W-1:0] facc, facc_next;
  logic [FCNT_W-1:0] fcnt, fcnt_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              stopped, stopped_next;
  logic              took;
  logic              is_digit;
  logic              is_sign;
  logic [31:0]       acc_step;
  logic [FACC_W-1:0] facc_step;

  assign pop       = !q_stat.empty && (!item.last || scale_idle);
  assign is_digit  = (item.cls == dtn_pkg::CLS_DIGIT);
  assign is_sign   = (item.cls == dtn_pkg::CLS_PLUS) || (item.cls == dtn_pkg::CLS_MINUS);
  assign acc_step  = 32'({acc, 3'b000} + {2'b00, acc, 1'b0} + 35'(item.digit));
  assign facc_step = FACC_W'({facc, 3'b000} + {2'b00, facc, 1'b0} + (FACC_W+3)'(item.digit));

  always_comb begin
    phase_next   = phase;
    neg_next     = neg;
    acc_next     = acc;
    seen_next    = seen;
    facc_next    = facc;
    fcnt_next    = fcnt;
    cnt_next     = cnt;
    stopped_next = stopped;
    took         = 1'b0;
    if (pop && !stopped) begin
      case (phase)
        PH_START: begin
          if ((mode != dtn_pkg::MODE_UINT) && is_sign) begin
            neg_next   = (item.cls == dtn_pkg::CLS_MINUS);
            phase_next = PH_WHOLE;
            took       = 1'b1;
          end else if (is_digit) begin
            acc_next   = acc_step;
            seen_next  = 1'b1;
            phase_next = PH_WHOLE;
            took       = 1'b1;
          end else begin
            stopped_next = 1'b1;
          end
        end
        PH_WHOLE: begin
          if (is_digit) begin
            acc_next  = acc_step;
            seen_next = 1'b1;
            took      = 1'b1;
          end else if (mode[1] && (item.cls == dtn_pkg::CLS_DOT) && seen) begin
            phase_next = PH_FRAC;
            took       = 1'b1;
          end else begin
            stopped_next = 1'b1;
          end
        end
        default: begin
          if (is_digit) begin
            if (fcnt < FCNT_W'(MAX_FRAC_DIGITS)) begin
              facc_next = facc_step;
              fcnt_next = FCNT_W'(fcnt + 1'b1);
            end
            took = 1'b1;
          end else begin
            stopped_next = 1'b1;
          end
        end
      endcase
      if (took && (cnt < CNT_W'(COUNT_MAX))) begin
        cnt_next = CNT_W'(cnt + 1'b1);
      end
    end
  end

  // Hand the field over on its last character, with that character applied.
  always_comb begin
    hand.valid = pop && item.last;
    hand.ok    = seen_next && ((phase_next != PH_FRAC) || (fcnt_next != '0));
    hand.neg   = neg_next;
    hand.mode  = mode;
    if ({{(17-CNT_W){1'b0}}, cnt_next} > 17'd255) begin
      hand.consumed = 8'hFF;
    end else begin
      hand.consumed = 8'(cnt_next);
    end
  end

  assign hand_acc  = acc_next;
  assign hand_facc = facc_next;
  assign hand_fcnt = fcnt_next;

  always_ff @(posedge clk) begin
    if (rst || (pop && item.last)) begin
      phase   <= PH_START;
      neg     <= 1'b0;
      acc     <= '0;
      seen    <= 1'b0;
      facc    <= '0;
      fcnt    <= '0;
      cnt     <= '0;
      stopped <= 1'b0;
    end else begin
      phase   <= phase_next;
      neg     <= neg_next;
      acc     <= acc_next;
      seen    <= seen_next;
      facc    <= facc_next;
      fcnt    <= fcnt_next;
      cnt     <= cnt_next;
      stopped <= stopped_next;
    end
  end

endmodule

[rtl/dtn_scale.sv]
// Result stage: divides the fraction by its power of ten one bit a cycle,
// applies sign and mode, and holds the result. Depends on dtn_pkg.
module dtn_scale #(
  parameter int FRAC_BITS       = dtn_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = dtn_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dtn_pkg::hand_ctl_t                     hand,
  input  logic [31:0]                            hand_acc,
  input  logic [$clog2(10**MAX_FRAC_DIGITS)-1:0] hand_facc,
  input  logic [$clog2(MAX_FRAC_DIGITS+1)-1:0]   hand_fcnt,
  output logic                                   scale_idle,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [dtn_pkg::VALUE_W-1:0]     number_value,
  output logic                                   parse_ok,
  output logic [7:0]                             chars_consumed
);

  localparam int PW    = dtn_pkg::POW10_W;
  localparam int TOT   = 32 + FRAC_BITS;
  localparam int IT_W  = $clog2(FRAC_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FORM = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]           state;
  logic [IT_W-1:0]      iter;
  logic [PW-1:0]        divisor;
  logic [PW-1:0]        rem;
  logic [FRAC_BITS-1:0] quo;
  logic [31:0]          acc;
  logic                 ok;
  logic                 neg;
  logic [1:0]           mode;
  logic [7:0]           consumed;
  logic [PW:0]          rem_dbl;
  logic                 q_bit;
  logic [31:0]          int_word;
  logic [TOT-1:0]       mag;
  logic [TOT-1:0]       real_word;
  logic signed [dtn_pkg::VALUE_W-1:0] value_next;

  assign scale_idle   = (state == S_IDLE);
  assign result_valid = (state == S_OUT);
  assign rem_dbl      = {rem, 1'b0};
  assign q_bit        = (rem_dbl >= {1'b0, divisor});

  always_comb begin
    int_word  = neg ? 32'(-acc) : acc;
    mag       = {acc, quo};
    real_word = neg ? TOT'(-mag) : mag;
    case (mode)
      dtn_pkg::MODE_UINT: value_next = {16'h0000, acc};
      dtn_pkg::MODE_SINT: value_next = dtn_pkg::VALUE_W'(signed'(int_word));
      default:            value_next = dtn_pkg::VALUE_W'(signed'(real_word));
    endcase
    if (!ok) begin
      value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (hand.valid) begin
          acc      <= hand_acc;
          ok       <= hand.ok;
          neg      <= hand.neg;
          mode     <= hand.mode;
          consumed <= hand.consumed;
          divisor  <= dtn_pkg::pow10(4'(hand_fcnt));
          rem      <= PW'(hand_facc);
          iter     <= '0;
        end
      end
      S_DIV: begin
        // Restoring step: one quotient bit per cycle.
        rem  <= q_bit ? PW'(rem_dbl - {1'b0, divisor}) : PW'(rem_dbl);
        quo  <= {quo[FRAC_BITS-2:0], q_bit};
        iter <= IT_W'(iter + 1'b1);
      end
      S_FORM: begin
        number_value   <= value_next;
        parse_ok       <= ok;
        chars_consumed <= consumed;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (hand.valid) state <= S_DIV;
        S_DIV:   if (iter == IT_W'(FRAC_BITS - 1)) state <= S_FORM;
        S_FORM:  state <= S_OUT;
        S_OUT:   if (!result_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/decimal_text_to_number.sv]
// Top level of the decimal text parser: register port, front, queue,
// parser and result stage. Depends on dtn_pkg and the defines header.
//
//  channel   signals                                   direction
//  char      char_valid/char_stall, char_code,         in
//            field_last
//  result    result_valid/result_stall, number_value,  out
//            parse_ok, chars_consumed
//  config    psel/penable/pwrite/paddr/pwdata/prdata   in/out
//
// Characters enter at one per cycle while char_stall is low; the parser
// applies one per cycle from the queue while the queue holds one.
// The last character of a field waits until the result stage is free. That
// stage runs a bit-serial divide of the fraction by its power of ten, so each
// result passes through load, FRAC_BITS divide steps, form and show there.
// Reset (rst, synchronous) empties the queue, clears the field and sets
// number_mode to the real form. char_stall rises only when the queue is full;
// a stalled result holds its value while the parser keeps consuming characters.
`include "decimal_text_to_number_defines.svh"

module decimal_text_to_number #(
  parameter int FRAC_BITS       = dtn_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = dtn_pkg::MAX_FRAC_DIGITS_DEF,
  parameter int COUNT_MAX       = dtn_pkg::COUNT_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dtn_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // character items
  input  logic                               char_valid,
  output logic                               char_stall,
  input  logic [7:0]                         char_code,
  input  logic                               field_last,
  // result items
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [dtn_pkg::VALUE_W-1:0] number_value,
  output logic                               parse_ok,
  output logic [7:0]                         chars_consumed
);

  logic [1:0]                             number_mode;
  logic                                   push;
  dtn_pkg::char_item_t                    push_item;
  dtn_pkg::char_item_t                    pop_item;
  logic                                   pop;
  dtn_pkg::queue_stat_t                   q_stat;
  dtn_pkg::hand_ctl_t                     hand;
  logic [31:0]                            hand_acc;
  logic [$clog2(10**MAX_FRAC_DIGITS)-1:0] hand_facc;
  logic [$clog2(MAX_FRAC_DIGITS+1)-1:0]   hand_fcnt;
  logic                                   scale_idle;

  // Register file: a single mode register; writes beyond it are dropped.
  assign pready = 1'b1;
  assign prdata = (paddr == dtn_pkg::ADDR_NUMBER_MODE) ? {30'd0, number_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode <= dtn_pkg::MODE_REAL;
    end else if (psel && penable && pwrite && pready
                 && (paddr == dtn_pkg::ADDR_NUMBER_MODE)) begin
      number_mode <= pwdata[1:0];
    end
  end

  // Classify characters as they arrive.
  dtn_front u_front (
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .field_last (field_last),
    .q_stat     (q_stat),
    .push       (push),
    .push_item  (push_item)
  );

  // Decouple the arrival side from the parser.
  dtn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Accumulate digits; hand the field over on its last character.
  dtn_parse #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
    .COUNT_MAX       (COUNT_MAX)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .mode       (number_mode),
    .q_stat     (q_stat),
    .item       (pop_item),
    .pop        (pop),
    .scale_idle (scale_idle),
    .hand       (hand),
    .hand_acc   (hand_acc),
    .hand_facc  (hand_facc),
    .hand_fcnt  (hand_fcnt)
  );

  // Scale the fraction, apply sign and mode, hold the result.
  dtn_scale #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_scale (
    .clk            (clk),
    .rst            (rst),
    .hand           (hand),
    .hand_acc       (hand_acc),
    .hand_facc      (hand_facc),
    .hand_fcnt      (hand_fcnt),
    .scale_idle     (scale_idle),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .number_value   (number_value),
    .parse_ok       (parse_ok),
    .chars_consumed (chars_consumed)
  );

  // A field is handed over only to an idle result stage, which then starts.
  `DTN_ASSERT(a_hand_when_idle, !hand.valid || scale_idle, "field handed to busy result stage")
  `DTN_ASSERT_NEXT(a_hand_taken, hand.valid, !scale_idle, "result stage missed a field")
  // A failed parse always reports zero.
  `DTN_ASSERT(a_fail_zero, !result_valid || parse_ok || (number_value == '0), "failed parse with nonzero value")
  // The queue cannot be full and empty at once.
  `DTN_ASSERT(a_queue_level, !(q_stat.full && q_stat.empty), "queue full and empty")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for decimal_text_to_number: drives text fields one
// character at a time, predicts each parsed result and checks it field by field.
// Depends on dtn_pkg and the decimal_text_to_number RTL only.
module tb_top;
  import dtn_pkg::*;

  // Mode 3 has no name in the package; the block treats it as the real form.
  localparam logic [1:0] MODE_REAL_ALT = 2'd3;
  localparam int Q_BITS       = 32 + FRAC_BITS_DEF;
  localparam int SETTLE       = FRAC_BITS_DEF + 24;  // result stage plus queue drain
  localparam int LONG_HOLD    = 400;                 // cycles of the long receiver hold-off
  localparam int PHASE_CHARS  = 115;                 // random characters per phase
  localparam int NUM_PHASES   = 8;
  localparam int DRAIN_LIMIT  = 50000;

  typedef enum logic [1:0] {AT_START, IN_WHOLE, IN_FRAC} scan_phase_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_profile_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      ok;
    logic [7:0]                consumed;
  } parse_result_t;

  // One entry per field sent: either a hand-written answer or a request
  // to take the predicted one.
  typedef struct packed {
    logic          given;
    parse_result_t answer;
  } field_answer_t;

  typedef struct {
    logic [1:0]    mode;
    string         text;
    logic          given;
    parse_result_t answer;
  } text_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic       char_valid   = 1'b0;
  logic       char_stall;
  logic [7:0] char_code    = '0;
  logic       field_last   = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;

  logic signed [VALUE_W-1:0] number_value;
  logic                      parse_ok;
  logic [7:0]                chars_consumed;

  // Predictor copy of the field state and the mode register.
  logic [1:0]  mode_shadow = MODE_REAL;
  scan_phase_t scan_phase  = AT_START;
  logic        sign_neg    = 1'b0;
  logic [31:0] whole_acc   = '0;
  logic        whole_seen  = 1'b0;
  logic [29:0] frac_acc    = '0;
  logic [3:0]  frac_cnt    = '0;
  logic [7:0]  char_cnt    = '0;
  logic        stopped     = 1'b0;

  parse_result_t pending_results[$];
  field_answer_t field_answers[$];
  text_row_t     text_rows[$];
  logic [7:0]    field_buf[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  logic squeeze_req = 1'b0;
  logic squeeze_done;
  int hold_left;

  int fail_cnt      = 0;
  int chars_taken   = 0;
  int fields_sent   = 0;
  int results_seen  = 0;
  int mode_writes   = 0;
  int phase_chars   = 0;

  decimal_text_to_number DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_code      (char_code),
    .field_last     (field_last),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .number_value   (number_value),
    .parse_ok       (parse_ok),
    .chars_consumed (chars_consumed)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: judge one character against the current mode.
  // ---------------------------------------------------------------------
  task automatic scan_char(input logic [7:0] ch);
    logic       is_digit;
    logic [3:0] dval;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dval     = 4'(ch - CH_ZERO);
    if (stopped) return;
    case (scan_phase)
      AT_START: begin
        if (mode_shadow != MODE_UINT && (ch == CH_PLUS || ch == CH_MINUS)) begin
          sign_neg   = (ch == CH_MINUS);
          scan_phase = IN_WHOLE;
          bump_count();
        end else if (is_digit) begin
          whole_acc  = whole_acc * 32'd10 + {28'd0, dval};
          whole_seen = 1'b1;
          scan_phase = IN_WHOLE;
          bump_count();
        end else begin
          stopped = 1'b1;
        end
      end
      IN_WHOLE: begin
        if (is_digit) begin
          whole_acc  = whole_acc * 32'd10 + {28'd0, dval};
          whole_seen = 1'b1;
          bump_count();
        end else if (mode_shadow >= MODE_REAL && ch == CH_DOT && whole_seen) begin
          scan_phase = IN_FRAC;
          bump_count();
        end else begin
          stopped = 1'b1;
        end
      end
      default: begin
        if (is_digit) begin
          // digits past the limit still count as consumed
          if (frac_cnt < MAX_FRAC_DIGITS_DEF) begin
            frac_acc = frac_acc * 30'd10 + {26'd0, dval};
            frac_cnt = frac_cnt + 4'd1;
          end
          bump_count();
        end else begin
          stopped = 1'b1;
        end
      end
    endcase
  endtask

  task automatic bump_count();
    if (char_cnt < 8'(COUNT_MAX_DEF)) char_cnt = char_cnt + 8'd1;
  endtask

  // Form the result of the field that just ended and clear the field state.
  task automatic finish_field(output parse_result_t res);
    logic [31:0] wval;
    logic [63:0] p10, frac, mag, v, span;
    res.ok       = whole_seen && (scan_phase != IN_FRAC || frac_cnt != 4'd0);
    res.consumed = char_cnt;
    res.value    = '0;
    if (res.ok) begin
      if (mode_shadow == MODE_UINT) begin
        res.value = {16'd0, whole_acc};
      end else if (mode_shadow == MODE_SINT) begin
        wval      = sign_neg ? (32'd0 - whole_acc) : whole_acc;
        res.value = {{16{wval[31]}}, wval};
      end else begin
        p10 = 64'd1;
        for (int i = 0; i < int'(frac_cnt); i++) p10 = p10 * 64'd10;
        frac = ({34'd0, frac_acc} << FRAC_BITS_DEF) / p10;
        mag  = ({32'd0, whole_acc} << FRAC_BITS_DEF) + frac;
        span = (64'd1 << Q_BITS) - 64'd1;
        // the sign applies even when the whole part is zero
        v = (sign_neg ? (64'd0 - mag) : mag) & span;
        if (v[Q_BITS-1]) v = v | ~span;
        res.value = v[VALUE_W-1:0];
      end
    end
    scan_phase = AT_START;
    sign_neg   = 1'b0;
    whole_acc  = '0;
    whole_seen = 1'b0;
    frac_acc   = '0;
    frac_cnt   = '0;
    char_cnt   = '0;
    stopped    = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Monitor: check results first, then step the predictor on each
  // accepted character. Both see the values from before the edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    parse_result_t want, got;
    field_answer_t ans;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        got = '{number_value, parse_ok, chars_consumed};
        if (pending_results.size() == 0) begin
          $error("result with no field pending: number_value %0d", $signed(number_value));
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value) begin
            $error("number_value: expected %0d, got %0d", $signed(want.value),
                   $signed(got.value));
            fail_cnt++;
          end
          if (got.ok !== want.ok) begin
            $error("parse_ok: expected %0d, got %0d", want.ok, got.ok);
            fail_cnt++;
          end
          if (got.consumed !== want.consumed) begin
            $error("chars_consumed: expected %0d, got %0d", want.consumed, got.consumed);
            fail_cnt++;
          end
        end
      end
      if (char_valid && !char_stall) begin
        chars_taken++;
        scan_char(char_code);
        if (field_last) begin
          finish_field(want);
          // use the hand-written answer where the row carries one
          if (field_answers.size() != 0) begin
            ans = field_answers.pop_front();
            if (ans.given) want = ans.answer;
          end
          pending_results.push_back(want);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request so the
  // queue fills and the block stalls its character input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
      squeeze_done <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done <= 1'b1;
      hold_left    <= LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------
  // Offer one character, with a random idle gap ahead of it; hold it until taken.
  task automatic send_char(input logic [7:0] code, input logic last);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= code;
    field_last <= last;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    phase_chars++;
  endtask

  // Send the characters in field_buf as one field.
  task automatic send_field(input logic given, input parse_result_t answer);
    field_answers.push_back('{given, answer});
    fields_sent++;
    foreach (field_buf[i]) send_char(field_buf[i], i == field_buf.size() - 1);
  endtask

  // Drop valid and wait until every expected result is in, then let the
  // result stage finish whatever it still holds.
  task automatic wait_idle();
    char_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write number_mode: setup cycle, then access cycle until pready.
  task automatic write_mode(input logic [1:0] m);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_NUMBER_MODE;
    pwdata  <= {30'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    mode_shadow  = m;
    mode_writes++;
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_junk();
    case ($urandom_range(4))
      0:       return CH_DOT;
      1:       return CH_PLUS;
      2:       return CH_MINUS;
      3:       return rand_digit();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Build a random field: mostly well-formed numbers for the mode, some
  // with a stray character, the rest raw noise.
  task automatic build_field(input logic [1:0] m);
    int   kind, nwhole, nfrac;
    logic nines;
    field_buf.delete();
    kind = $urandom_range(99);
    if (kind < 80) begin
      if (m != MODE_UINT && $urandom_range(2) == 0)
        field_buf.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      nines  = ($urandom_range(9) == 0);
      nwhole = ($urandom_range(7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 5);
      repeat (nwhole) field_buf.push_back(nines ? CH_NINE : rand_digit());
      if (m >= MODE_REAL && $urandom_range(3) != 0) begin
        field_buf.push_back(CH_DOT);
        nfrac = ($urandom_range(5) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 5);
        repeat (nfrac) field_buf.push_back(nines ? CH_NINE : rand_digit());
      end
      if (kind >= 62) field_buf.insert($urandom_range(field_buf.size()), pick_junk());
    end else begin
      repeat ($urandom_range(1, 6))
        field_buf.push_back($urandom_range(1) ? 8'($urandom_range(255)) : pick_junk());
    end
  endtask

  task automatic add_row(input logic [1:0] m, input string txt, input logic given,
                         input logic signed [VALUE_W-1:0] val, input logic ok,
                         input logic [7:0] cnt);
    text_row_t r;
    r.mode   = m;
    r.text   = txt;
    r.given  = given;
    r.answer = '{val, ok, cnt};
    text_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------------
  // Timeout
  // ---------------------------------------------------------------------
  initial begin
    #2000000;
    $error("run timed out");
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [1:0]    phase_mode;
    idle_profile_t profile;
    int            guard;

    // Directed rows. Rows marked 1 carry an answer read straight off the
    // rules; the others take the prediction.
    // real form, straight after reset
    add_row(MODE_REAL, "1.5",                  1, 48'sd98304, 1, 3);
    add_row(MODE_REAL, ".5",                   1, 48'sd0, 0, 0);   // dot with no whole digit
    add_row(MODE_REAL, "1.",                   1, 48'sd0, 0, 2);   // dot with no fraction
    add_row(MODE_REAL, "-0.5",                 1, -48'sd32768, 1, 4); // sign on a zero whole part
    add_row(MODE_REAL, "+7.x",                 1, 48'sd0, 0, 3);
    add_row(MODE_REAL, "1.05",                 0, 48'sd0, 0, 0);   // leading zero in fraction
    add_row(MODE_REAL, "0.1234567891234",      0, 48'sd0, 0, 0);   // extra fraction digits
    add_row(MODE_REAL, "4294967295.999999999", 0, 48'sd0, 0, 0);
    add_row(MODE_REAL, "\377",                 1, 48'sd0, 0, 0);
    // unsigned integer
    add_row(MODE_UINT, "0",                    1, 48'sd0, 1, 1);
    add_row(MODE_UINT, "4294967295",           1, 48'sd4294967295, 1, 10);
    add_row(MODE_UINT, "4294967296",           1, 48'sd0, 1, 10); // wraps
    add_row(MODE_UINT, "-5",                   1, 48'sd0, 0, 0);   // sign stops unsigned
    add_row(MODE_UINT, "12.5",                 1, 48'sd12, 1, 2);
    // signed integer
    add_row(MODE_SINT, "-2147483648",          1, -48'sd2147483648, 1, 11);
    add_row(MODE_SINT, "+2147483647",          1, 48'sd2147483647, 1, 11);
    add_row(MODE_SINT, "2147483648",           1, -48'sd2147483648, 1, 10);
    add_row(MODE_SINT, "-",                    1, 48'sd0, 0, 1);
    add_row(MODE_SINT, "--1",                  1, 48'sd0, 0, 1);
    add_row(MODE_SINT, "7a9",                  0, 48'sd0, 0, 0);
    // mode 3 acts as the real form
    add_row(MODE_REAL_ALT, "-1.25",            0, 48'sd0, 0, 0);
    add_row(MODE_REAL_ALT, "-0",               0, 48'sd0, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed rows; change the mode only once the block is idle.
    foreach (text_rows[r]) begin
      if (text_rows[r].mode != mode_shadow) begin
        wait_idle();
        write_mode(text_rows[r].mode);
      end
      field_buf.delete();
      for (int i = 0; i < text_rows[r].text.len(); i++)
        field_buf.push_back(text_rows[r].text[i]);
      send_field(text_rows[r].given, text_rows[r].answer);
    end

    // Random phases: rotate through every mode and every idle profile.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      phase_mode = 2'(ph % 4);
      profile    = idle_profile_t'((ph + ph / 4) % 4);
      wait_idle();
      write_mode(phase_mode);
      case (profile)
        IDLE_NONE:     begin send_idle_pct = 0;  stall_pct <= 0;  end
        IDLE_SENDER:   begin send_idle_pct = 56; stall_pct <= 0;  end
        IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct <= 56; end
        default:       begin send_idle_pct = 8;  stall_pct <= 8;  end
      endcase
      phase_chars = 0;
      if (ph == 0) begin
        // hold the result side off while the sender keeps pushing
        squeeze_req <= 1'b1;
        // long integer: the count saturates and the value wraps
        field_buf.delete();
        repeat (258) field_buf.push_back(rand_digit());
        send_field(0, '0);
      end
      if (ph == 2) begin
        // long fraction: digits past the limit are consumed, count saturates
        field_buf.delete();
        field_buf.push_back(CH_MINUS);
        field_buf.push_back(CH_ZERO);
        field_buf.push_back(CH_DOT);
        repeat (256) field_buf.push_back(rand_digit());
        send_field(0, '0);
      end
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        build_field(phase_mode);
        send_field(0, '0);
      end
    end

    // Drain: wait for every expected result, with a bound.
    char_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_cnt++;
    end
    repeat (SETTLE * 2) @(posedge clk);

    $display("Run covered %0d characters in %0d fields under %0d mode writes (all four modes)",
             chars_taken, fields_sent, mode_writes);
    $display("Compared %0d results across four idle profiles; %0d mismatches",
             results_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
